[rtl/core/pec_pkg.sv]
// ----------------------------------------------------------------------------
// pec_pkg
// Shared types and codes of the pin entry access controller: item and
// result structs, event codes, item kinds, key codes and register indexes.
// ----------------------------------------------------------------------------
package pec_pkg;

  // event reported with every result
  typedef enum logic [3:0] {
    EvNone     = 4'd0,
    EvDigit    = 4'd1,
    EvGranted  = 4'd2,
    EvWrong    = 4'd3,
    EvLockout  = 4'd4,
    EvOpened   = 4'd5,
    EvClosed   = 4'd6,
    EvStatus   = 4'd7,
    EvLogout   = 4'd8,
    EvInvalid  = 4'd9,
    EvDoorbell = 4'd10
  } evt_e;

  // item kinds
  localparam logic [1:0] KindKey    = 2'd0;
  localparam logic [1:0] KindSerial = 2'd1;
  localparam logic [1:0] KindButton = 2'd2;

  // key and character codes
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChOpenU   = 8'h4F;
  localparam logic [7:0] ChOpenL   = 8'h6F;
  localparam logic [7:0] ChCloseU  = 8'h43;
  localparam logic [7:0] ChCloseL  = 8'h63;
  localparam logic [7:0] ChStatusU = 8'h53;
  localparam logic [7:0] ChStatusL = 8'h73;
  localparam logic [7:0] ChLogoutU = 8'h4C;
  localparam logic [7:0] ChLogoutL = 8'h6C;

  // configuration register indexes
  localparam logic CfgPinCode     = 1'b0;
  localparam logic CfgMaxFailures = 1'b1;

  // register reset values
  localparam logic [15:0] PinCodeReset     = 16'h2580;
  localparam logic [3:0]  MaxFailuresReset = 4'd3;
  localparam logic [3:0]  FailSaturate     = 4'd15;

  // one input item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic       button_level;
  } item_t;

  // one result item
  typedef struct packed {
    evt_e       event_res;
    logic       door_open;
    logic       is_authenticated;
    logic [3:0] failures;
    logic       is_locked;
  } res_t;

endpackage

[rtl/core/pec_in_stage.sv]
// ----------------------------------------------------------------------------
// pec_in_stage
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module pec_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  pec_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           in_stall_o,
  output logic           item_valid_o,
  output pec_pkg::item_t item_o
);

  logic           valid_q;
  pec_pkg::item_t item_q;
  logic           take;

  // stall only while a held item cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[rtl/core/pec_core.sv]
// ----------------------------------------------------------------------------
// pec_core
// Lock state and the per-item decision: digit entry and code compare,
// session commands, doorbell edge detect and lockout.
// ----------------------------------------------------------------------------
module pec_core #(
  parameter int CODE_LENGTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  pec_pkg::item_t item_i,
  input  logic [15:0]    pin_code_i,
  input  logic [3:0]     max_failures_i,
  output pec_pkg::res_t  res_o
);

  localparam int CntW = $clog2(CODE_LENGTH + 1);
  localparam int IdxW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [CntW-1:0] LastPos = CntW'(CODE_LENGTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CODE_LENGTH);

  logic [3:0]      entry_q [CODE_LENGTH];
  logic [CntW-1:0] count_q, count_d;
  logic [3:0]      fail_q, fail_d;
  logic            auth_q, auth_d;
  logic            door_q, door_d;
  logic            lock_q, lock_d;
  logic            btn_q, btn_d;

  logic [3:0]      code_nib [CODE_LENGTH];
  logic [CntW-1:0] pos;
  logic [3:0]      digit;
  logic            is_digit;
  logic            dig_we;
  logic            match;
  logic [3:0]      fail_inc;
  pec_pkg::evt_e   ev;

  // code digit per entry position, zero beyond the register
  for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_nib
    localparam int K = CODE_LENGTH - 1 - g;
    if (K < 4) begin : g_in
      assign code_nib[g] = pin_code_i[K*4 +: 4];
    end else begin : g_out
      assign code_nib[g] = 4'd0;
    end
  end

  // digit decode and compare of a full entry
  always_comb begin
    is_digit = (item_i.char_code >= pec_pkg::ChZero) &&
               (item_i.char_code <= pec_pkg::ChNine);
    // ascii digits keep their value in the low nibble
    digit    = item_i.char_code[3:0];
    pos      = (count_q >= FullCnt) ? '0 : count_q;
    match    = (digit == code_nib[CODE_LENGTH-1]);
    for (int i = 0; i < CODE_LENGTH - 1; i++) begin
      if (entry_q[i] != code_nib[i]) begin
        match = 1'b0;
      end
    end
    fail_inc = (fail_q == pec_pkg::FailSaturate) ? fail_q : fail_q + 4'd1;
  end

  // next state and event
  always_comb begin
    ev      = pec_pkg::EvNone;
    count_d = count_q;
    fail_d  = fail_q;
    auth_d  = auth_q;
    door_d  = door_q;
    lock_d  = lock_q;
    btn_d   = btn_q;
    dig_we  = 1'b0;
    if (!lock_q) begin
      if ((item_i.kind == pec_pkg::KindKey || item_i.kind == pec_pkg::KindSerial)
          && !auth_q) begin
        // code entry
        if (is_digit) begin
          if (pos != LastPos) begin
            dig_we  = 1'b1;
            count_d = CntW'(pos + 1'b1);
            ev      = pec_pkg::EvDigit;
          end else begin
            count_d = '0;
            if (match) begin
              fail_d = 4'd0;
              auth_d = 1'b1;
              ev     = pec_pkg::EvGranted;
            end else begin
              fail_d = fail_inc;
              if (fail_inc >= max_failures_i) begin
                lock_d = 1'b1;
                ev     = pec_pkg::EvLockout;
              end else begin
                ev = pec_pkg::EvWrong;
              end
            end
          end
        end
      end else if (item_i.kind == pec_pkg::KindKey) begin
        // keypad commands in session
        if (item_i.char_code == pec_pkg::ChHash) begin
          auth_d  = 1'b0;
          door_d  = 1'b0;
          count_d = '0;
          ev      = pec_pkg::EvLogout;
        end else if (item_i.char_code == pec_pkg::ChStar) begin
          ev = pec_pkg::EvStatus;
        end
      end else if (item_i.kind == pec_pkg::KindSerial) begin
        // serial commands in session
        unique case (item_i.char_code)
          pec_pkg::ChOpenU, pec_pkg::ChOpenL: begin
            door_d = 1'b1;
            ev     = pec_pkg::EvOpened;
          end
          pec_pkg::ChCloseU, pec_pkg::ChCloseL: begin
            door_d = 1'b0;
            ev     = pec_pkg::EvClosed;
          end
          pec_pkg::ChStatusU, pec_pkg::ChStatusL: begin
            ev = pec_pkg::EvStatus;
          end
          pec_pkg::ChLogoutU, pec_pkg::ChLogoutL: begin
            auth_d  = 1'b0;
            door_d  = 1'b0;
            count_d = '0;
            ev      = pec_pkg::EvLogout;
          end
          default: begin
            ev = pec_pkg::EvInvalid;
          end
        endcase
      end else if (item_i.kind == pec_pkg::KindButton) begin
        // doorbell on falling level
        if (!item_i.button_level && btn_q) begin
          ev = pec_pkg::EvDoorbell;
          if (!auth_q) begin
            count_d = '0;
          end
        end
        btn_d = item_i.button_level;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fail_q  <= 4'd0;
      auth_q  <= 1'b0;
      door_q  <= 1'b0;
      lock_q  <= 1'b0;
      btn_q   <= 1'b1;
    end else if (fire_i) begin
      count_q <= count_d;
      fail_q  <= fail_d;
      auth_q  <= auth_d;
      door_q  <= door_d;
      lock_q  <= lock_d;
      btn_q   <= btn_d;
    end
  end

  // entry buffer
  always_ff @(posedge clk_i) begin
    if (fire_i && dig_we) begin
      entry_q[pos[IdxW-1:0]] <= digit;
    end
  end

  assign res_o = '{event_res:        ev,
                   door_open:        door_d,
                   is_authenticated: auth_d,
                   failures:         fail_d,
                   is_locked:        lock_d};

endmodule

[rtl/core/pec_out_stage.sv]
// ----------------------------------------------------------------------------
// pec_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module pec_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  pec_pkg::res_t res_i,
  input  logic          out_stall_i,
  output logic          ready_o,
  output logic          out_valid_o,
  output pec_pkg::res_t res_o
);

  logic          valid_q;
  pec_pkg::res_t res_q;

  // free when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[rtl/core/pin_entry_access_controller.sv]
// ----------------------------------------------------------------------------
// pin_entry_access_controller
// Keypad combination lock with failure count and permanent lockout.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one item per transfer: a
// keypad key, a serial character or a doorbell button sample. Every item
// gives exactly one result on the output channel (out_valid_o /
// out_stall_i): the event code and the door, session, failure and lock
// flags after the item.
// The item waits in the input register, then the decision logic loads
// the result register, from which the result can transfer to the receiver.
// Throughput is one item per cycle while the receiver does not stall;
// the lock state is updated as the item moves into the result register,
// so the next item sees it at once.
// When the receiver stalls, the result holds, one more item waits in the
// input register and then in_stall_o rises.
// The configuration port writes pin_code (index 0) or max_failures
// (index 1) on any cycle with cfg_we_i high; write it only while idle.
// Reset clears both channels, the session and lock flags and the failure
// count, and loads code 2580 and a limit of three wrong codes.
// ----------------------------------------------------------------------------
module pin_entry_access_controller #(
  parameter int CODE_LENGTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_code_i,
  input  logic        button_level_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_res_o,
  output logic        door_open_o,
  output logic        is_authenticated_o,
  output logic [3:0]  failures_o,
  output logic        is_locked_o,
  // configuration port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic           item_valid;
  logic           out_ready;
  logic           fire;
  pec_pkg::item_t in_item;
  pec_pkg::item_t item;
  pec_pkg::res_t  res_next;
  pec_pkg::res_t  res;
  logic [15:0]    pin_code_q;
  logic [3:0]     max_failures_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_code_q     <= pec_pkg::PinCodeReset;
      max_failures_q <= pec_pkg::MaxFailuresReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == pec_pkg::CfgPinCode) begin
        pin_code_q <= cfg_data_i;
      end
      if (cfg_index_i == pec_pkg::CfgMaxFailures) begin
        max_failures_q <= cfg_data_i[3:0];
      end
    end
  end

  assign in_item = '{kind: kind_i, char_code: char_code_i, button_level: button_level_i};
  assign fire    = item_valid && out_ready;

  pec_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .item_i       (in_item),
    .advance_i    (out_ready),
    .in_stall_o   (in_stall_o),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  pec_core #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .item_i         (item),
    .pin_code_i     (pin_code_q),
    .max_failures_i (max_failures_q),
    .res_o          (res_next)
  );

  pec_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (item_valid),
    .res_i       (res_next),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign event_res_o        = res.event_res;
  assign door_open_o        = res.door_open;
  assign is_authenticated_o = res.is_authenticated;
  assign failures_o         = res.failures;
  assign is_locked_o        = res.is_locked;

endmodule

[rtl/core/pec_checker.sv]
// ----------------------------------------------------------------------------
// pec_checker
// Port-level checks of the pin entry access controller, bound to the top.
// ----------------------------------------------------------------------------
module pec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  event_res_o,
  input logic        door_open_o,
  input logic        is_authenticated_o,
  input logic [3:0]  failures_o,
  input logic        is_locked_o
);

  logic out_xfer;
  logic seen_lock_q;

  assign out_xfer = out_valid_o && !out_stall_i;

  // remembers a delivered locked result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_lock_q <= 1'b0;
    end else if (out_xfer && is_locked_o) begin
      seen_lock_q <= 1'b1;
    end
  end

  // lockout is permanent and silent
  a_lock_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_lock_q |-> is_locked_o && event_res_o == pec_pkg::EvNone)
    else $error("result after lockout is not locked and silent");

  // a grant opens a session with a clean count
  a_grant_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == pec_pkg::EvGranted
    |-> is_authenticated_o && failures_o == 4'd0 && !is_locked_o)
    else $error("grant without session or with failures");

  // lockout only outside a session
  a_lockout_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == pec_pkg::EvLockout
    |-> is_locked_o && !is_authenticated_o && !door_open_o)
    else $error("lockout event with inconsistent flags");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o)
    && $stable(failures_o))
    else $error("stalled result changed");

  // input stalls only behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

endmodule

bind pin_entry_access_controller pec_checker u_pec_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .event_res_o        (event_res_o),
  .door_open_o        (door_open_o),
  .is_authenticated_o (is_authenticated_o),
  .failures_o         (failures_o),
  .is_locked_o        (is_locked_o)
);
